// ----- hw/rtl/bsps_pkg.sv -----
package bsps_pkg;

	typedef struct packed {
		logic              req_type;
		logic signed [7:0] goal_angle;
		logic signed [7:0] measured_angle;
	} bsps_in_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [1:0]        drive_dir;
		logic [10:0]       pwm_compare;
		logic [4:0]        on_time_ms;
		logic [5:0]        off_time_ms;
		logic signed [7:0] move_target;
	} bsps_out_t;

	typedef struct packed {
		logic signed [7:0] angle_min;
		logic [6:0]        angle_max;
		logic [6:0]        tolerance;
		logic [5:0]        max_pulses;
		logic [7:0]        max_error;
	} bsps_cfg_t;

	typedef struct packed {
		logic              moving;
		logic signed [7:0] held_target;
		logic [6:0]        pulse_count;
		logic              final_check_due;
	} bsps_state_t;

	localparam logic REQ_START  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic [2:0] ST_IGNORED = 3'd0;
	localparam logic [2:0] ST_STARTED = 3'd1;
	localparam logic [2:0] ST_PULSE   = 3'd2;
	localparam logic [2:0] ST_REACHED = 3'd3;
	localparam logic [2:0] ST_INVALID = 3'd4;
	localparam logic [2:0] ST_TOO_BIG = 3'd5;
	localparam logic [2:0] ST_CLOSE   = 3'd6;
	localparam logic [2:0] ST_FAILED  = 3'd7;

	localparam logic [1:0] DIR_OFF = 2'd0;
	localparam logic [1:0] DIR_POS = 2'd1;
	localparam logic [1:0] DIR_NEG = 2'd2;

	localparam logic signed [7:0] ANGLE_INVALID = -8'sd127;

	localparam logic [7:0] BAND_HIGH = 8'd20;
	localparam logic [7:0] BAND_MID  = 8'd10;
	localparam logic [7:0] BAND_LOW  = 8'd5;

	localparam logic [10:0] PWM_HIGH = 11'd2000;
	localparam logic [10:0] PWM_MID  = 11'd1500;
	localparam logic [10:0] PWM_LOW  = 11'd1300;
	localparam logic [10:0] PWM_MIN  = 11'd1000;

	localparam logic [4:0] ON_HIGH = 5'd25;
	localparam logic [4:0] ON_MID  = 5'd22;
	localparam logic [4:0] ON_LOW  = 5'd20;
	localparam logic [4:0] ON_MIN  = 5'd17;

	localparam logic [5:0] OFF_PULSE = 6'd50;

	localparam logic [2:0] REG_ANGLE_MIN  = 3'd0;
	localparam logic [2:0] REG_ANGLE_MAX  = 3'd1;
	localparam logic [2:0] REG_TOLERANCE  = 3'd2;
	localparam logic [2:0] REG_MAX_PULSES = 3'd3;
	localparam logic [2:0] REG_MAX_ERROR  = 3'd4;

	localparam logic signed [7:0] RST_ANGLE_MIN  = -8'sd45;
	localparam logic [6:0]        RST_ANGLE_MAX  = 7'd45;
	localparam logic [6:0]        RST_TOLERANCE  = 7'd1;
	localparam logic [5:0]        RST_MAX_PULSES = 6'd25;
	localparam logic [7:0]        RST_MAX_ERROR  = 8'd180;

endpackage

// ----- hw/rtl/bsps_cfg.sv -----
module bsps_cfg
	import bsps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output bsps_cfg_t   cfg
);

	logic [2:0] idx;
	logic       wr_en;
	bsps_cfg_t  cfg_q;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_min  <= RST_ANGLE_MIN;
			cfg_q.angle_max  <= RST_ANGLE_MAX;
			cfg_q.tolerance  <= RST_TOLERANCE;
			cfg_q.max_pulses <= RST_MAX_PULSES;
			cfg_q.max_error  <= RST_MAX_ERROR;
		end else if (wr_en) begin
			unique case (idx)
				REG_ANGLE_MIN:  cfg_q.angle_min  <= $signed(pwdata[7:0]);
				REG_ANGLE_MAX:  cfg_q.angle_max  <= pwdata[6:0];
				REG_TOLERANCE:  cfg_q.tolerance  <= pwdata[6:0];
				REG_MAX_PULSES: cfg_q.max_pulses <= pwdata[5:0];
				REG_MAX_ERROR:  cfg_q.max_error  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ANGLE_MIN:  prdata = {{24{cfg_q.angle_min[7]}}, cfg_q.angle_min};
			REG_ANGLE_MAX:  prdata = {25'd0, cfg_q.angle_max};
			REG_TOLERANCE:  prdata = {25'd0, cfg_q.tolerance};
			REG_MAX_PULSES: prdata = {26'd0, cfg_q.max_pulses};
			REG_MAX_ERROR:  prdata = {24'd0, cfg_q.max_error};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// ----- hw/rtl/bsps_eval.sv -----
module bsps_eval
	import bsps_pkg::*;
(
	input  bsps_in_t    item,
	input  bsps_state_t cur,
	input  bsps_cfg_t   cfg,
	output bsps_state_t nxt,
	output bsps_out_t   res
);

	logic signed [8:0] tgt_ext;
	logic signed [8:0] max_ext;
	logic signed [8:0] min_ext;
	logic signed [8:0] clamp_a;
	logic signed [8:0] clamp_b;
	logic signed [8:0] err;
	logic [8:0]        err_abs;
	logic [7:0]        mag;
	logic              within_tol;
	logic [6:0]        pc_inc;

	assign tgt_ext    = {item.goal_angle[7], item.goal_angle};
	assign max_ext    = $signed({2'b00, cfg.angle_max});
	assign min_ext    = {cfg.angle_min[7], cfg.angle_min};
	assign clamp_a    = (tgt_ext > max_ext) ? max_ext : tgt_ext;
	assign clamp_b    = (clamp_a < min_ext) ? min_ext : clamp_a;
	assign err        = {cur.held_target[7], cur.held_target}
	                  - {item.measured_angle[7], item.measured_angle};
	assign err_abs    = err[8] ? 9'(-err) : 9'(err);
	assign mag        = err_abs[7:0];
	assign within_tol = mag <= {1'b0, cfg.tolerance};
	assign pc_inc     = (cur.pulse_count <= {1'b0, cfg.max_pulses})
	                  ? cur.pulse_count + 7'd1 : cur.pulse_count;

	always_comb begin
		nxt             = cur;
		res.status      = ST_IGNORED;
		res.drive_dir   = DIR_OFF;
		res.pwm_compare = '0;
		res.on_time_ms  = '0;
		res.off_time_ms = '0;
		if (item.req_type == REQ_START) begin
			nxt.held_target     = clamp_b[7:0];
			nxt.moving          = 1'b1;
			nxt.pulse_count     = '0;
			nxt.final_check_due = 1'b0;
			res.status          = ST_STARTED;
		end else if (cur.moving) begin
			if (cur.final_check_due) begin
				res.status          = within_tol ? ST_CLOSE : ST_FAILED;
				nxt.moving          = 1'b0;
				nxt.final_check_due = 1'b0;
			end else if (item.measured_angle == ANGLE_INVALID) begin
				res.status = ST_INVALID;
				nxt.moving = 1'b0;
			end else if (within_tol) begin
				res.status = ST_REACHED;
				nxt.moving = 1'b0;
			end else if (mag > cfg.max_error) begin
				res.status = ST_TOO_BIG;
				nxt.moving = 1'b0;
			end else begin
				res.status      = ST_PULSE;
				res.drive_dir   = err[8] ? DIR_NEG : DIR_POS;
				res.off_time_ms = OFF_PULSE;
				if (mag > BAND_HIGH) begin
					res.pwm_compare = PWM_HIGH;
					res.on_time_ms  = ON_HIGH;
				end else if (mag > BAND_MID) begin
					res.pwm_compare = PWM_MID;
					res.on_time_ms  = ON_MID;
				end else if (mag > BAND_LOW) begin
					res.pwm_compare = PWM_LOW;
					res.on_time_ms  = ON_LOW;
				end else begin
					res.pwm_compare = PWM_MIN;
					res.on_time_ms  = ON_MIN;
				end
				nxt.pulse_count = pc_inc;
				if (pc_inc > {1'b0, cfg.max_pulses}) begin
					nxt.final_check_due = 1'b1;
				end
			end
		end
		res.move_target = nxt.held_target;
	end

endmodule

// ----- hw/rtl/banded_steering_position_stepper.sv -----
// Banded steering position stepper.
// Requests enter on in_valid/in_ready with an in_data struct: a start request
// clamps the target angle and arms a move, a sample request is judged against
// the held target and drives a pulse or ends the move; it is ignored when idle.
// Every request gives exactly one result on out_valid/out_ready (out_data).
// An accepted request sits in the input register while the compare and band
// select run; it moves on once the result register is free or being taken,
// and the result register then holds the outcome until it is taken.
// Throughput: one request per cycle while out_ready is high; the held target,
// pulse count and armed flags update in the same cycle that a result is written.
// When the receiver stalls, the result register holds its value and the input
// register holds one more request; in_ready drops once both are full and rises
// again as soon as the result is taken.
// Limits and thresholds sit on an APB port (32-bit data, registers at 4*i,
// pready tied high); write them only while no request is in flight.
// Reset clears the move state and loads the default limits; no result is
// pending after reset.
module banded_steering_position_stepper
	import bsps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  bsps_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output bsps_out_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	bsps_cfg_t   cfg;
	bsps_state_t state_q;
	bsps_state_t state_nxt;
	bsps_in_t    item_s1;
	logic        valid_s1;
	bsps_out_t   res_nxt;
	bsps_out_t   res_s2;
	logic        valid_s2;
	logic        advance;

	bsps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bsps_eval u_eval (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign advance   = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready  = ~valid_s1 | advance;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready & in_valid) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

endmodule
